### rtl/core/slm_pkg.sv
package slm_pkg;

  // Field widths
  localparam int OP_W   = 2;
  localparam int BLK_W  = 16;
  localparam int ST_W   = 2;
  localparam int SLOT_W = 5;
  localparam int AGE_W  = 8;
  localparam int ROW_W  = BLK_W + AGE_W;

  // Defaults for the top level parameters
  localparam int NUM_SLOTS_DEF = 32;
  localparam int DISK_SIZE_DEF = 8192;

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  // Request codes (op 3 behaves as a lookup)
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd1;
  localparam logic [OP_W-1:0] OP_MARK   = 2'd2;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_OOB  = 2'd1;
  localparam logic [ST_W-1:0] ST_MISS = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // capture request, clear scan trackers
    logic rd_en;   // read one slot row, advance scan address
    logic commit;  // update slot state and load the result word
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic oob;     // captured block number is beyond the disk
    logic last;    // scan address is at the last slot
  } sts_t;

endpackage

### rtl/core/slm_ctrl.sv
module slm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  slm_pkg::sts_t sts,
  output slm_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.oob) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd_en = 1'b1;
          if (sts.last) begin
            state_next = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        // last row is evaluated in this cycle
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || !out_stall))
    else $error("result committed over an untaken word");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en && sts.last) |=> (state == S_DRAIN))
    else $error("scan did not stop at the last slot");

endmodule

### rtl/core/slm_datapath.sv
module slm_datapath #(
  parameter int NUM_SLOTS = slm_pkg::NUM_SLOTS_DEF,
  parameter int DISK_SIZE = slm_pkg::DISK_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  slm_pkg::cmd_t              cmd,
  output slm_pkg::sts_t              sts,
  input  logic [slm_pkg::OP_W-1:0]   op,
  input  logic [slm_pkg::BLK_W-1:0]  block_num,
  output logic [slm_pkg::ST_W-1:0]   status,
  output logic [slm_pkg::SLOT_W-1:0] slot,
  output logic                       writeback,
  output logic [slm_pkg::BLK_W-1:0]  writeback_block
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int BLK_W = slm_pkg::BLK_W;
  localparam int AGE_W = slm_pkg::AGE_W;
  localparam int ROW_W = slm_pkg::ROW_W;

  // Slot flags in flops, block and age rows in a memory
  logic [NUM_SLOTS-1:0] valid;
  logic [NUM_SLOTS-1:0] dirty;
  logic [ROW_W-1:0]     mem [NUM_SLOTS];

  // Captured request
  logic [slm_pkg::OP_W-1:0] op_q;
  logic [BLK_W-1:0]         blk_q;
  logic                     is_alloc;
  logic                     is_mark;

  // Scan pipeline
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_vld;
  logic [ROW_W-1:0] rdata;
  logic [BLK_W-1:0] rd_blk;
  logic [AGE_W-1:0] rd_age;
  logic [AGE_W-1:0] new_age;
  logic             rd_slot_valid;

  // Scan trackers
  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [AGE_W-1:0] max_age;
  logic [IDX_W-1:0] max_idx;
  logic [BLK_W-1:0] max_blk;

  // Commit results
  logic [IDX_W-1:0]         pick;
  logic                     wb;
  logic [slm_pkg::ST_W-1:0] st_res;
  logic [IDX_W-1:0]         slot_res;
  logic                     claim;
  logic                     set_dirty;
  logic                     age_wr;

  assign is_alloc = (op_q == slm_pkg::OP_ALLOC);
  assign is_mark  = (op_q == slm_pkg::OP_MARK);

  assign sts.oob  = ({1'b0, blk_q} >= 17'(DISK_SIZE));
  assign sts.last = (rd_addr == IDX_W'(NUM_SLOTS - 1));

  assign rd_blk        = rdata[ROW_W-1:AGE_W];
  assign rd_age        = rdata[AGE_W-1:0];
  assign new_age       = (rd_age == slm_pkg::AGE_MAX) ? rd_age : rd_age + 1'b1;
  assign rd_slot_valid = valid[rd_idx];
  assign age_wr        = rd_vld && is_alloc && rd_slot_valid;

  // Request capture and scan address
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= op;
      blk_q <= block_num;
    end
    if (cmd.accept) begin
      rd_addr <= '0;
    end else if (cmd.rd_en) begin
      rd_addr <= rd_addr + 1'b1;
    end
    rd_idx <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
    end
  end

  // Row memory: one read, one write per cycle
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
    if (claim) begin
      mem[pick] <= {blk_q, AGE_W'(0)};
    end else if (age_wr) begin
      mem[rd_idx] <= {rd_blk, new_age};
    end
  end

  // Scan evaluation: first hit, first free, oldest valid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.accept) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      max_age    <= '0;
      max_idx    <= '0;
    end else if (rd_vld) begin
      if (!is_alloc && rd_slot_valid && rd_blk == blk_q && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= rd_idx;
      end
      if (is_alloc && !rd_slot_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
      // aged values are at least one, so the first valid slot always seeds the search
      if (is_alloc && rd_slot_valid && new_age > max_age) begin
        max_age <= new_age;
        max_idx <= rd_idx;
        max_blk <= rd_blk;
      end
    end
  end

  // Result selection
  always_comb begin
    pick      = free_found ? free_idx : max_idx;
    wb        = 1'b0;
    st_res    = slm_pkg::ST_OK;
    slot_res  = '0;
    claim     = 1'b0;
    set_dirty = 1'b0;
    if (sts.oob) begin
      st_res = slm_pkg::ST_OOB;
    end else if (is_alloc) begin
      wb       = !free_found && dirty[max_idx];
      slot_res = pick;
      claim    = cmd.commit;
    end else if (hit_found) begin
      slot_res  = hit_idx;
      set_dirty = cmd.commit && is_mark;
    end else begin
      st_res = slm_pkg::ST_MISS;
    end
  end

  // Slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      dirty <= '0;
    end else if (claim) begin
      valid[pick] <= 1'b1;
      dirty[pick] <= 1'b0;
    end else if (set_dirty) begin
      dirty[hit_idx] <= 1'b1;
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status          <= st_res;
      slot            <= slm_pkg::SLOT_W'(slot_res);
      writeback       <= wb;
      writeback_block <= wb ? max_blk : '0;
    end
  end

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(claim && age_wr))
    else $error("row memory written twice in one cycle");

  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    hit_found |-> valid[hit_idx])
    else $error("lookup hit on a free slot");

  a_hit_lowest: assert property (@(posedge clk) disable iff (rst)
    (hit_found && rd_vld) |=> $stable(hit_idx))
    else $error("later slot replaced the lowest hit");

endmodule

### rtl/core/buffer_slot_manager_lru.sv
// Channel  Direction  Handshake            Word
// in       input      in_valid / in_stall  op, block_num
// out      output     out_valid / out_stall status, slot, writeback, writeback_block
//
// A result word is presented after its request is accepted and the datapath
// has walked the slot row memory one slot per cycle, evaluated the last row and
// committed; an out of bound block skips the walk and goes straight to the commit.
// The next request can be taken in the cycle after the commit.
// Reset (rst, synchronous) frees every slot; no clearing pass is needed.
// in_stall is high while a request is in work; a result waits in the output
// register while the next request is taken, and holds while out_stall is high.
module buffer_slot_manager_lru #(
  parameter int NUM_SLOTS = slm_pkg::NUM_SLOTS_DEF,
  parameter int DISK_SIZE = slm_pkg::DISK_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [slm_pkg::OP_W-1:0]   op,
  input  logic [slm_pkg::BLK_W-1:0]  block_num,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [slm_pkg::ST_W-1:0]   status,
  output logic [slm_pkg::SLOT_W-1:0] slot,
  output logic                       writeback,
  output logic [slm_pkg::BLK_W-1:0]  writeback_block
);

  slm_pkg::cmd_t cmd;
  slm_pkg::sts_t sts;

  slm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  slm_datapath #(
    .NUM_SLOTS (NUM_SLOTS),
    .DISK_SIZE (DISK_SIZE)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .op              (op),
    .block_num       (block_num),
    .status          (status),
    .slot            (slot),
    .writeback       (writeback),
    .writeback_block (writeback_block)
  );

endmodule
